@@ design/ikh_pkg.sv @@
// ikh_pkg: shared types and constants for the integer key hash unit
// no dependencies; imported by every module of the block
`default_nettype none

package ikh_pkg;

    // item modes
    typedef enum logic [2:0] {
        MODE_HASH32    = 3'd0,
        MODE_HASH64    = 3'd1,
        MODE_SEEDED    = 3'd2,
        MODE_MW_START  = 3'd3,
        MODE_MW_FOLD   = 3'd4
    } ikh_mode_t;

    localparam int unsigned KEY_W    = 64;
    localparam int unsigned HASH_W   = 32;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned RESULT_W = 30;
    localparam int unsigned FOLD_ROT = 7;

endpackage : ikh_pkg

`default_nettype wire

@@ design/ikh_mix32.sv @@
// ikh_mix32: 32-bit shift-add-xor integer mixer, result masked to 30 bits
// depends on ikh_pkg
`default_nettype none

module ikh_mix32
    import ikh_pkg::*;
(
    input  wire logic [HASH_W-1:0] din,
    output logic      [HASH_W-1:0] dout
);

    logic [HASH_W-1:0] s1;
    logic [HASH_W-1:0] s2;
    logic [HASH_W-1:0] s3;
    logic [HASH_W-1:0] s4;
    logic [HASH_W-1:0] s5;
    logic [HASH_W-1:0] s6;

    // mixing chain, all arithmetic wraps at 32 bits
    always_comb
    begin
        s1 = ~din + (din << 15);
        s2 = s1 ^ (s1 >> 12);
        s3 = s2 + (s2 << 2);
        s4 = s3 ^ (s3 >> 4);
        // multiply by 2057 as shift-adds
        s5 = s4 + (s4 << 3) + (s4 << 11);
        s6 = s5 ^ (s5 >> 16);
        dout = {{(HASH_W-RESULT_W){1'b0}}, s6[RESULT_W-1:0]};
    end

endmodule : ikh_mix32

`default_nettype wire

@@ design/ikh_mix64.sv @@
// ikh_mix64: 64-bit shift-add-xor integer mixer, low 30 bits returned
// depends on ikh_pkg
`default_nettype none

module ikh_mix64
    import ikh_pkg::*;
(
    input  wire logic [KEY_W-1:0]  din,
    output logic      [HASH_W-1:0] dout
);

    logic [KEY_W-1:0] s1;
    logic [KEY_W-1:0] s2;
    logic [KEY_W-1:0] s3;
    logic [KEY_W-1:0] s4;
    logic [KEY_W-1:0] s5;
    logic [KEY_W-1:0] s6;

    // mixing chain, all arithmetic wraps at 64 bits
    always_comb
    begin
        s1 = ~din + (din << 18);
        s2 = s1 ^ (s1 >> 31);
        // multiply by 21 as shift-adds
        s3 = s2 + (s2 << 2) + (s2 << 4);
        s4 = s3 ^ (s3 >> 11);
        s5 = s4 + (s4 << 6);
        s6 = s5 ^ (s5 >> 22);
        dout = {{(HASH_W-RESULT_W){1'b0}}, s6[RESULT_W-1:0]};
    end

endmodule : ikh_mix64

`default_nettype wire

@@ design/integer_key_hash_unit.sv @@
// integer_key_hash_unit: top level with input register, mixers and result register
// depends on ikh_pkg, ikh_mix32 and ikh_mix64
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode and key_value; output
//   channel (out_valid/out_ready) returns one hash_value per transfer.
//   The user must load the seed through cfg_wr_en/cfg_wr_data only while the block
//   is idle; the block does not enforce this. Path: an item taken sits in the input
//   register, is mixed and lands in the result register once that is free;
//   out_valid is high from then. Throughput: one item per cycle while out_ready
//   frees the result register; the mixers are a single combinational pass between
//   the two registers, and the running hash is updated in the same cycle the result
//   is registered, so fold items may follow directly. Stall: if a result waits on
//   out_ready, an empty input register takes one more item, then in_ready drops
//   until the result leaves. Reset: both registers empty, running hash and seed zero.
`default_nettype none

module integer_key_hash_unit
    import ikh_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [KEY_W-1:0]  key_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [HASH_W-1:0] hash_value,
    input  wire logic              cfg_wr_en,
    input  wire logic [KEY_W-1:0]  cfg_wr_data
);

    logic              in_valid_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              out_valid_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] running_reg;
    logic [HASH_W-1:0] running_next;
    logic [KEY_W-1:0]  seed_reg;
    logic              advance;
    logic [HASH_W-1:0] m32_in;
    logic [HASH_W-1:0] m32_out;
    logic [KEY_W-1:0]  m64_in;
    logic [HASH_W-1:0] m64_out;
    logic [HASH_W-1:0] rotated;

    // handshake: result register frees when empty or taken
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign hash_value = hash_reg;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_wr_en)
            seed_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            key_reg  <= key_value;
        end
    end

    // mixer operand selection
    always_comb
    begin
        if (mode_reg == MODE_MW_START)
            m32_in = {{(HASH_W-1){1'b0}}, key_reg[0]};
        else
            m32_in = key_reg[HASH_W-1:0];

        if (mode_reg == MODE_SEEDED)
            m64_in = {{(KEY_W-HASH_W){1'b0}}, key_reg[HASH_W-1:0]} ^ seed_reg;
        else
            m64_in = key_reg;
    end

    ikh_mix32 u_mix32 (
        .din  (m32_in),
        .dout (m32_out)
    );

    ikh_mix64 u_mix64 (
        .din  (m64_in),
        .dout (m64_out)
    );

    assign rotated = {running_reg[HASH_W-FOLD_ROT-1:0], running_reg[HASH_W-1:HASH_W-FOLD_ROT]};

    // result and running hash selection
    always_comb
    begin
        running_next = running_reg;
        case (mode_reg)
            MODE_HASH32:   hash_next = m32_out;
            MODE_HASH64,
            MODE_SEEDED:   hash_next = m64_out;
            MODE_MW_START:
            begin
                running_next = m32_out;
                hash_next    = m32_out;
            end
            MODE_MW_FOLD:
            begin
                running_next = rotated ^ m64_out;
                hash_next    = rotated ^ m64_out;
            end
            default:       hash_next = '0;
        endcase
    end

    // result register and running hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            running_reg   <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
                running_reg <= running_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            hash_reg <= hash_next;
    end

endmodule : integer_key_hash_unit

`default_nettype wire
